[hdl/grid_element_connectivity_unit_assert.svh]
// Assertion macros for the grid element connectivity unit
`ifndef GRID_ELEMENT_CONNECTIVITY_UNIT_ASSERT_SVH
`define GRID_ELEMENT_CONNECTIVITY_UNIT_ASSERT_SVH

// antecedent |-> consequent, checked on every rising clock edge outside reset
`define GEC_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// antecedent |=> consequent
`define GEC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/gec_pkg.sv]
package gec_pkg;

   localparam int MaxDim = 256;
   localparam int DimW   = $clog2(MaxDim + 1);   // 9
   localparam int CrdW   = $clog2(MaxDim);       // 8
   localparam int IdxW   = 27;
   localparam int PtW    = 24;
   localparam int CntW   = 4;
   localparam int CfgW   = 9;
   localparam int RegIdxW = 2;
   localparam int ProdW  = 3 * DimW;             // room for any list length

   typedef enum logic [1:0] {
      FUNC_EDGE = 2'd0,
      FUNC_TRI  = 2'd1,
      FUNC_QUAD = 2'd2,
      FUNC_HEXA = 2'd3
   } func_type;

   typedef enum logic [RegIdxW-1:0] {
      REG_SIZE_X = 2'd0,
      REG_SIZE_Y = 2'd1,
      REG_SIZE_Z = 2'd2,
      REG_NONE   = 2'd3
   } reg_idx_type;

   typedef struct packed {
      logic [1:0]      func;
      logic [IdxW-1:0] element_index;
   } req_type;

   typedef struct packed {
      logic [PtW-1:0]  corner0;
      logic [PtW-1:0]  corner1;
      logic [PtW-1:0]  corner2;
      logic [PtW-1:0]  corner3;
      logic [PtW-1:0]  corner4;
      logic [PtW-1:0]  corner5;
      logic [PtW-1:0]  corner6;
      logic [PtW-1:0]  corner7;
      logic [CntW-1:0] corner_count;
      logic            in_range;
   } rsp_type;

endpackage

[hdl/grid_element_connectivity_unit.sv]
// Grid element connectivity unit. Takes one request per cycle while rsp_ready
// does not stall it and returns one response per request, in order. Two entry
// stages let the registered list lengths settle after a size write. The two
// 27-stage radix-2 dividers that split the element index into x, y and z set
// most of the pipeline depth. A stall on rsp_ready freezes the whole pipeline.
// The user must write size registers through csr_* only while the unit is idle;
// the unit does not enforce this. A size of zero counts as one, and sizes above
// 256 saturate.
module grid_element_connectivity_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write,
   input  logic [gec_pkg::RegIdxW-1:0]   csr_index,
   input  logic [gec_pkg::CfgW-1:0]      csr_data,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  gec_pkg::req_type              req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output gec_pkg::rsp_type              rsp_payload
);
   import gec_pkg::*;

   localparam int DivLat = IdxW + 1;

   logic [CfgW-1:0] size_x_ff, size_y_ff, size_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff <= CfgW'(2);
         size_y_ff <= CfgW'(2);
         size_z_ff <= CfgW'(2);
      end else if (csr_write) begin
         unique case (reg_idx_type'(csr_index))
            REG_SIZE_X: size_x_ff <= csr_data;
            REG_SIZE_Y: size_y_ff <= csr_data;
            REG_SIZE_Z: size_z_ff <= csr_data;
            default: ;
         endcase
      end
   end

   function automatic logic [DimW-1:0] clamp_dim(input logic [CfgW-1:0] v);
      if (v == '0) return DimW'(1);
      if (v > CfgW'(MaxDim)) return DimW'(MaxDim);
      return DimW'(v);
   endfunction

   logic [DimW-1:0] gx, gy, gz, gx1, gy1, gz1;
   assign gx  = clamp_dim(size_x_ff);
   assign gy  = clamp_dim(size_y_ff);
   assign gz  = clamp_dim(size_z_ff);
   assign gx1 = gx - DimW'(1);
   assign gy1 = gy - DimW'(1);
   assign gz1 = gz - DimW'(1);

   // List lengths are constant between config writes; registered in two levels
   logic [2*DimW-1:0] pxy_ff, px1y_ff, pxy1_ff, px1y1_ff;
   logic [ProdW-1:0]  ex_ff, ey_ff, ez_ff, qxy_ff, qxz_ff, qyz_ff, nh_ff;
   always_ff @(posedge clock) begin
      pxy_ff   <= gx * gy;
      px1y_ff  <= gx1 * gy;
      pxy1_ff  <= gx * gy1;
      px1y1_ff <= gx1 * gy1;
      ex_ff    <= px1y_ff * gz;
      ey_ff    <= pxy1_ff * gz;
      ez_ff    <= pxy_ff * gz1;
      qxy_ff   <= px1y1_ff * gz;
      qxz_ff   <= px1y_ff * gz1;
      qyz_ff   <= pxy1_ff * gz1;
      nh_ff    <= px1y1_ff * gz1;
   end

   logic advance;
   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   // Entry stages: cover the two register levels of the length products after a size write
   logic    pre_valid_ff [2];
   req_type pre_req_ff [2];
   always_ff @(posedge clock) begin
      if (reset) begin
         pre_valid_ff[0] <= 1'b0;
         pre_valid_ff[1] <= 1'b0;
      end else if (advance) begin
         pre_valid_ff[0] <= req_valid;
         pre_valid_ff[1] <= pre_valid_ff[0];
      end
      if (advance) begin
         pre_req_ff[0] <= req_payload;
         pre_req_ff[1] <= pre_req_ff[0];
      end
   end

   // Stage 1: sub-list selection
   logic            s1_valid_ff;
   logic [1:0]      s1_func_ff;
   logic            s1_half_ff;
   logic [IdxW-1:0] s1_idx_ff;
   logic [1:0]      s1_sub_ff;
   logic            s1_ok_ff;
   logic [DimW-1:0] s1_dx_ff, s1_dy_ff;

   logic [ProdW-1:0] i_idx, l0, l1, l2;
   always_comb begin
      i_idx = (pre_req_ff[1].func == FUNC_TRI) ? ProdW'(pre_req_ff[1].element_index >> 1)
                                               : ProdW'(pre_req_ff[1].element_index);
      unique case (func_type'(pre_req_ff[1].func))
         FUNC_EDGE: begin l0 = ex_ff;  l1 = ey_ff;  l2 = ez_ff;  end
         FUNC_HEXA: begin l0 = nh_ff;  l1 = '0;     l2 = '0;     end
         default:   begin l0 = qxy_ff; l1 = qxz_ff; l2 = qyz_ff; end
      endcase
   end

   logic [ProdW-1:0] s1_rest_in;
   logic [1:0]       s1_sub_in;
   logic             s1_ok_in;
   logic [DimW-1:0]  s1_dx_in, s1_dy_in;
   always_comb begin
      s1_rest_in = i_idx;
      s1_sub_in  = 2'd0;
      s1_ok_in   = 1'b1;
      priority if (i_idx < l0) begin
         s1_sub_in = 2'd0;
      end else if (i_idx - l0 < l1) begin
         s1_rest_in = i_idx - l0;
         s1_sub_in  = 2'd1;
      end else if (i_idx - l0 - l1 < l2) begin
         s1_rest_in = i_idx - l0 - l1;
         s1_sub_in  = 2'd2;
      end else begin
         s1_ok_in = 1'b0;
      end
      s1_dx_in = gx1;
      s1_dy_in = gy1;
      unique case (func_type'(pre_req_ff[1].func))
         FUNC_EDGE: begin
            s1_dx_in = (s1_sub_in == 2'd0) ? gx1 : gx;
            s1_dy_in = (s1_sub_in == 2'd1) ? gy1 : gy;
         end
         FUNC_HEXA: ;
         default: begin
            s1_dx_in = (s1_sub_in == 2'd2) ? gx : gx1;
            s1_dy_in = (s1_sub_in == 2'd1) ? gy : gy1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) s1_valid_ff <= 1'b0;
      else if (advance) s1_valid_ff <= pre_valid_ff[1];
      if (advance) begin
         s1_func_ff <= pre_req_ff[1].func;
         s1_half_ff <= pre_req_ff[1].element_index[0];
         s1_idx_ff  <= IdxW'(s1_rest_in);
         s1_sub_ff  <= s1_sub_in;
         s1_ok_ff   <= s1_ok_in;
         s1_dx_ff   <= s1_dx_in;
         s1_dy_ff   <= s1_dy_in;
      end
   end

   // Divider A: idx / dx
   logic [IdxW-1:0] qa;
   logic [DimW-1:0] ra;
   gec_divmod u_div_x (
      .clock(clock), .reset(reset), .advance(advance),
      .dividend(s1_idx_ff), .divisor(s1_dx_ff),
      .quotient(qa), .remainder(ra)
   );

   // Side info delay lines across the dividers
   typedef struct packed {
      logic            valid;
      logic [1:0]      func;
      logic            half;
      logic [1:0]      sub;
      logic            ok;
      logic [DimW-1:0] dy;
      logic [CrdW-1:0] x;
   } side_type;

   side_type da_ff [DivLat];
   side_type db_ff [DivLat];
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < DivLat; s++) begin
            da_ff[s].valid <= 1'b0;
            db_ff[s].valid <= 1'b0;
         end
      end else if (advance) begin
         da_ff[0] <= '{valid: s1_valid_ff, func: s1_func_ff, half: s1_half_ff,
                       sub: s1_sub_ff, ok: s1_ok_ff, dy: s1_dy_ff, x: '0};
         db_ff[0] <= '{valid: da_ff[DivLat-1].valid, func: da_ff[DivLat-1].func,
                       half: da_ff[DivLat-1].half, sub: da_ff[DivLat-1].sub,
                       ok: da_ff[DivLat-1].ok, dy: da_ff[DivLat-1].dy,
                       x: CrdW'(ra)};
         for (int s = 1; s < DivLat; s++) begin
            da_ff[s] <= da_ff[s-1];
            db_ff[s] <= db_ff[s-1];
         end
      end
   end

   logic [IdxW-1:0] qb;
   logic [DimW-1:0] rb;
   gec_divmod u_div_y (
      .clock(clock), .reset(reset), .advance(advance),
      .dividend(qa), .divisor(da_ff[DivLat-1].dy),
      .quotient(qb), .remainder(rb)
   );

   // Stages 2 and 3: base point: x + gx*(y + gy*z)
   side_type        s2_ff;
   logic [PtW-1:0]  s2_zy_ff;
   always_ff @(posedge clock) begin
      if (reset) s2_ff.valid <= 1'b0;
      else if (advance) begin
         s2_ff    <= db_ff[DivLat-1];
         s2_zy_ff <= PtW'(PtW'(qb) * PtW'(gy) + PtW'(rb));
      end
   end

   logic [PtW-1:0] s3_base_ff, s3_sx_ff, s3_sy_ff, s3_sz_ff;
   side_type       s3_ff;
   always_ff @(posedge clock) begin
      if (reset) s3_ff.valid <= 1'b0;
      else if (advance) begin
         s3_ff      <= s2_ff;
         s3_base_ff <= PtW'(s2_zy_ff * PtW'(gx) + PtW'(s2_ff.x));
         s3_sx_ff   <= PtW'(1);
         s3_sy_ff   <= PtW'(gx);
         s3_sz_ff   <= PtW'(pxy_ff);
      end
   end

   // Stage 4: corner assembly
   logic [PtW-1:0] a, b, c, d, p;
   logic [PtW-1:0] c_in [8];
   logic [CntW-1:0] cnt_in;
   always_comb begin
      p = s3_base_ff;
      a = s3_sx_ff;
      b = s3_sy_ff;
      d = s3_sz_ff;
      c = '0;
      for (int k = 0; k < 8; k++) c_in[k] = '0;
      cnt_in = '0;
      unique case (func_type'(s3_ff.func))
         FUNC_EDGE: begin
            c = (s3_ff.sub == 2'd0) ? a : (s3_ff.sub == 2'd1) ? b : d;
            c_in[0] = p;
            c_in[1] = p + c;
            cnt_in  = CntW'(2);
         end
         FUNC_HEXA: begin
            c_in[0] = p;         c_in[1] = p + a;
            c_in[2] = p + a + b; c_in[3] = p + b;
            c_in[4] = p + d;     c_in[5] = p + a + d;
            c_in[6] = p + a + b + d; c_in[7] = p + b + d;
            cnt_in  = CntW'(8);
         end
         default: begin
            // quad plane: first step u, second step v
            logic [PtW-1:0] u, v;
            u = (s3_ff.sub == 2'd2) ? b : a;
            v = (s3_ff.sub == 2'd0) ? b : d;
            c = p + u + v;
            if (s3_ff.func == FUNC_TRI) begin
               c_in[0] = p;
               c_in[1] = s3_ff.half ? c : p + u;
               c_in[2] = s3_ff.half ? p + v : c;
               cnt_in  = CntW'(3);
            end else begin
               c_in[0] = p; c_in[1] = p + u; c_in[2] = c; c_in[3] = p + v;
               cnt_in  = CntW'(4);
            end
         end
      endcase
      if (!s3_ff.ok) begin
         for (int k = 0; k < 8; k++) c_in[k] = '0;
         cnt_in = '0;
      end
   end

   rsp_type rsp_ff;
   logic    rsp_valid_ff;
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (advance) rsp_valid_ff <= s3_ff.valid;
      if (advance) begin
         rsp_ff <= '{corner0: c_in[0], corner1: c_in[1], corner2: c_in[2],
                     corner3: c_in[3], corner4: c_in[4], corner5: c_in[5],
                     corner6: c_in[6], corner7: c_in[7],
                     corner_count: cnt_in, in_range: s3_ff.ok};
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
endmodule

[hdl/gec_divmod.sv]
// Pipelined restoring divide of an unsigned value by a divisor of DimW bits.
// One quotient bit per stage; the remainder fits in DimW bits.
module gec_divmod (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  logic [gec_pkg::IdxW-1:0]  dividend,
   input  logic [gec_pkg::DimW-1:0]  divisor,
   output logic [gec_pkg::IdxW-1:0]  quotient,
   output logic [gec_pkg::DimW-1:0]  remainder
);
   import gec_pkg::*;

   localparam int RemW = DimW + 1;

   logic [IdxW-1:0] quo_ff [IdxW+1];
   logic [RemW-1:0] rem_ff [IdxW+1];
   logic [DimW-1:0] dsr_ff [IdxW+1];
   logic [IdxW-1:0] quo_in [IdxW+1];
   logic [RemW-1:0] rem_in [IdxW+1];

   always_comb begin
      quo_in[0] = dividend;
      rem_in[0] = '0;
      for (int s = 0; s < IdxW; s++) begin
         logic [RemW-1:0] trial;
         trial = {rem_ff[s][DimW-1:0], quo_ff[s][IdxW-1]};
         if (trial >= {1'b0, dsr_ff[s]}) begin
            rem_in[s+1] = trial - {1'b0, dsr_ff[s]};
            quo_in[s+1] = {quo_ff[s][IdxW-2:0], 1'b1};
         end else begin
            rem_in[s+1] = trial;
            quo_in[s+1] = {quo_ff[s][IdxW-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         quo_ff[0] <= quo_in[0];
         rem_ff[0] <= rem_in[0];
         dsr_ff[0] <= divisor;
         for (int s = 1; s <= IdxW; s++) begin
            quo_ff[s] <= quo_in[s];
            rem_ff[s] <= rem_in[s];
            dsr_ff[s] <= dsr_ff[s-1];
         end
      end
   end

   assign quotient  = quo_ff[IdxW];
   assign remainder = rem_ff[IdxW][DimW-1:0];

   logic unused_reset;
   assign unused_reset = reset;
endmodule

[hdl/gec_checker.sv]
`include "grid_element_connectivity_unit_assert.svh"
module gec_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input gec_pkg::rsp_type rsp_payload
);
   import gec_pkg::*;

   `GEC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload), "response dropped while stalled")
   `GEC_ASSERT_IMPL(a_count_range, clock, reset, rsp_valid, rsp_payload.in_range == (rsp_payload.corner_count != '0), "count disagrees with in_range")
   `GEC_ASSERT_IMPL(a_ready_flow, clock, reset, rsp_ready || !rsp_valid, req_ready, "input blocked without output stall")
   `GEC_ASSERT_IMPL(a_edge_zero, clock, reset, rsp_valid && rsp_payload.corner_count == CntW'(2), rsp_payload.corner2 == '0 && rsp_payload.corner7 == '0, "edge with extra corners")
endmodule

bind grid_element_connectivity_unit gec_checker u_gec_checker (
   .clock(clock), .reset(reset), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload)
);

[tb/sv/tb.sv]
`timescale 1ns / 100ps

module tb;
   import gec_pkg::*;

   localparam int LATENCY = 2 * IdxW + 8;
   localparam longint CYCLE_LIMIT = 1500000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write = 1'b0;
   logic [RegIdxW-1:0] csr_index = REG_SIZE_X;
   logic [CfgW-1:0] csr_data = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_payload;

   grid_element_connectivity_unit dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // current size registers as written
   logic [CfgW-1:0] reg_sx = 9'd2, reg_sy = 9'd2, reg_sz = 9'd2;
   rsp_type corners_due[$];
   int error_count = 0;
   longint cycle_count = 0;
   bit rx_idle_on = 1'b1;
   bit tx_idle_on = 1'b1;
   int hold_off = 0;

   function automatic longint clamp_size(logic [CfgW-1:0] v);
      if (v == 0) return 1;
      if (v > MaxDim) return MaxDim;
      return v;
   endfunction

   function automatic rsp_type grid_element(req_type r);
      rsp_type o;
      longint nx, ny, nz, e, cnt, len, q, x, y, z, dx, dy;
      longint c[8];
      longint qc[4];
      int mode; // sub-list: 0 X/XY, 1 Y/XZ, 2 Z/YZ
      bit ok;
      o = '0;
      nx = clamp_size(reg_sx);
      ny = clamp_size(reg_sy);
      nz = clamp_size(reg_sz);
      e = r.element_index;
      foreach (c[i]) c[i] = 0;
      ok = 0;
      cnt = 0;
      case (func_type'(r.func))
         FUNC_EDGE: begin
            cnt = 2;
            mode = -1;
            len = (nx - 1) * ny * nz;
            if (e < len) begin mode = 0; dx = nx - 1; dy = ny; end
            else begin
               e -= len;
               len = nx * (ny - 1) * nz;
               if (e < len) begin mode = 1; dx = nx; dy = ny - 1; end
               else begin
                  e -= len;
                  len = nx * ny * (nz - 1);
                  if (e < len) begin mode = 2; dx = nx; dy = ny; end
               end
            end
            if (mode >= 0) begin
               ok = 1;
               x = e % dx; y = (e / dx) % dy; z = (e / dx) / dy;
               c[0] = x + nx * (y + ny * z);
               c[1] = (x + (mode == 0)) + nx * ((y + (mode == 1)) + ny * (z + (mode == 2)));
            end
         end
         FUNC_HEXA: begin
            cnt = 8;
            if (e < (nx - 1) * (ny - 1) * (nz - 1)) begin
               ok = 1;
               x = e % (nx - 1); y = (e / (nx - 1)) % (ny - 1); z = (e / (nx - 1)) / (ny - 1);
               for (int k = 0; k < 8; k++) begin
                  longint ax, ay;
                  ax = x + ((k == 1 || k == 2 || k == 5 || k == 6) ? 1 : 0);
                  ay = y + ((k == 2 || k == 3 || k == 6 || k == 7) ? 1 : 0);
                  c[k] = ax + nx * (ay + ny * (z + (k >= 4)));
               end
            end
         end
         default: begin
            cnt = (r.func == FUNC_TRI) ? 3 : 4;
            q = (r.func == FUNC_TRI) ? (e >> 1) : e;
            mode = -1;
            len = (nx - 1) * (ny - 1) * nz;
            if (q < len) begin mode = 0; dx = nx - 1; dy = ny - 1; end
            else begin
               q -= len;
               len = (nx - 1) * ny * (nz - 1);
               if (q < len) begin mode = 1; dx = nx - 1; dy = ny; end
               else begin
                  q -= len;
                  len = nx * (ny - 1) * (nz - 1);
                  if (q < len) begin mode = 2; dx = nx; dy = ny - 1; end
               end
            end
            if (mode >= 0) begin
               ok = 1;
               x = q % dx; y = (q / dx) % dy; z = (q / dx) / dy;
               qc[0] = x + nx * (y + ny * z);
               case (mode)
                  0: begin
                     qc[1] = (x + 1) + nx * (y + ny * z);
                     qc[2] = (x + 1) + nx * ((y + 1) + ny * z);
                     qc[3] = x + nx * ((y + 1) + ny * z);
                  end
                  1: begin
                     qc[1] = (x + 1) + nx * (y + ny * z);
                     qc[2] = (x + 1) + nx * (y + ny * (z + 1));
                     qc[3] = x + nx * (y + ny * (z + 1));
                  end
                  default: begin
                     qc[1] = x + nx * ((y + 1) + ny * z);
                     qc[2] = x + nx * ((y + 1) + ny * (z + 1));
                     qc[3] = x + nx * (y + ny * (z + 1));
                  end
               endcase
               c[0] = qc[0];
               if (r.func == FUNC_QUAD) begin
                  c[1] = qc[1]; c[2] = qc[2]; c[3] = qc[3];
               end else if (e[0] == 1'b0) begin
                  c[1] = qc[1]; c[2] = qc[2];
               end else begin
                  c[1] = qc[2]; c[2] = qc[3];
               end
            end
         end
      endcase
      if (!ok) return '0;
      o.corner0 = c[0][PtW-1:0]; o.corner1 = c[1][PtW-1:0];
      o.corner2 = c[2][PtW-1:0]; o.corner3 = c[3][PtW-1:0];
      o.corner4 = c[4][PtW-1:0]; o.corner5 = c[5][PtW-1:0];
      o.corner6 = c[6][PtW-1:0]; o.corner7 = c[7][PtW-1:0];
      o.corner_count = cnt[CntW-1:0];
      o.in_range = 1'b1;
      return o;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("tb: mismatch %s got %0d want %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // response checker
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_valid && rsp_ready) begin
         if (corners_due.size() == 0) begin
            report_mismatch("unexpected transfer", 1, 0);
         end else begin
            rsp_type w;
            w = corners_due.pop_front();
            if (rsp_payload.corner0 !== w.corner0) report_mismatch("corner0", rsp_payload.corner0, w.corner0);
            if (rsp_payload.corner1 !== w.corner1) report_mismatch("corner1", rsp_payload.corner1, w.corner1);
            if (rsp_payload.corner2 !== w.corner2) report_mismatch("corner2", rsp_payload.corner2, w.corner2);
            if (rsp_payload.corner3 !== w.corner3) report_mismatch("corner3", rsp_payload.corner3, w.corner3);
            if (rsp_payload.corner4 !== w.corner4) report_mismatch("corner4", rsp_payload.corner4, w.corner4);
            if (rsp_payload.corner5 !== w.corner5) report_mismatch("corner5", rsp_payload.corner5, w.corner5);
            if (rsp_payload.corner6 !== w.corner6) report_mismatch("corner6", rsp_payload.corner6, w.corner6);
            if (rsp_payload.corner7 !== w.corner7) report_mismatch("corner7", rsp_payload.corner7, w.corner7);
            if (rsp_payload.corner_count !== w.corner_count)
               report_mismatch("corner_count", rsp_payload.corner_count, w.corner_count);
            if (rsp_payload.in_range !== w.in_range)
               report_mismatch("in_range", rsp_payload.in_range, w.in_range);
         end
      end
   end

   // receiver: random stall bursts, or a long counted hold-off
   initial begin
      int gap;
      @(negedge clock);
      forever begin
         if (hold_off > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold_off) @(negedge clock);
            hold_off = 0;
         end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 9);
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("tb: failure");
      $finish;
   end

   // valid stays high into the next call so items can follow back to back
   task automatic send_request(func_type f, logic [IdxW-1:0] idx);
      req_type r;
      r.func = f;
      r.element_index = idx;
      @(negedge clock);
      if (tx_idle_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      corners_due = {corners_due, grid_element(r)};
   endtask

   task automatic drain;
      @(negedge clock);
      req_valid <= 1'b0;
      while (corners_due.size() != 0) @(negedge clock);
      repeat (LATENCY + 10) @(negedge clock);
   endtask

   task automatic write_size(reg_idx_type which, logic [CfgW-1:0] v);
      csr_write <= 1'b1;
      csr_index <= which;
      csr_data <= v;
      @(negedge clock);
      case (which)
         REG_SIZE_X: reg_sx = v;
         REG_SIZE_Y: reg_sy = v;
         REG_SIZE_Z: reg_sz = v;
         default: ;
      endcase
   endtask

   task automatic set_grid(logic [CfgW-1:0] a, logic [CfgW-1:0] b, logic [CfgW-1:0] c);
      drain();
      write_size(REG_SIZE_X, a);
      write_size(REG_SIZE_Y, b);
      write_size(REG_SIZE_Z, c);
      csr_write <= 1'b0;
   endtask

   function automatic longint list_length(func_type f);
      longint nx, ny, nz, quads;
      nx = clamp_size(reg_sx); ny = clamp_size(reg_sy); nz = clamp_size(reg_sz);
      quads = (nx - 1) * (ny - 1) * nz + (nx - 1) * ny * (nz - 1) + nx * (ny - 1) * (nz - 1);
      case (f)
         FUNC_EDGE: return (nx - 1) * ny * nz + nx * (ny - 1) * nz + nx * ny * (nz - 1);
         FUNC_TRI:  return 2 * quads;
         FUNC_QUAD: return quads;
         default:   return (nx - 1) * (ny - 1) * (nz - 1);
      endcase
   endfunction

   // mostly in-range indices, some just past the end, some anywhere
   function automatic logic [IdxW-1:0] pick_index(func_type f);
      longint n;
      n = list_length(f);
      case ($urandom_range(0, 9))
         0: return IdxW'($urandom());
         1: return IdxW'(n + $urandom_range(0, 3));
         default: return (n > 0) ? IdxW'($urandom_range(0, n - 1)) : IdxW'($urandom_range(0, 7));
      endcase
   endfunction

   task automatic test_reset_grid;
      for (int f = 0; f < 4; f++) begin
         send_request(func_type'(f), '0);
         send_request(func_type'(f), IdxW'(list_length(func_type'(f)) - 1));
         send_request(func_type'(f), IdxW'(list_length(func_type'(f))));
      end
      send_request(FUNC_EDGE, {IdxW{1'b1}});
   endtask

   task automatic test_extremes;
      set_grid(9'd256, 9'd256, 9'd256);
      for (int f = 0; f < 4; f++) begin
         send_request(func_type'(f), IdxW'(list_length(func_type'(f)) - 1));
         send_request(func_type'(f), IdxW'(list_length(func_type'(f))));
      end
      send_request(FUNC_TRI, 27'h5555555);
      set_grid(9'd0, 9'd511, 9'd300);   // zero and oversized sizes
      send_request(FUNC_EDGE, 27'd3);
      send_request(FUNC_QUAD, 27'd7);
      send_request(FUNC_HEXA, 27'd0);
      set_grid(9'd1, 9'd1, 9'd1);       // every list empty
      send_request(FUNC_EDGE, 27'd0);
      send_request(FUNC_TRI, 27'd0);
   endtask

   task automatic random_phase(int n);
      for (int i = 0; i < n; i++) begin
         func_type f;
         f = func_type'($urandom_range(0, 3));
         send_request(f, pick_index(f));
      end
   endtask

   task automatic test_random_grids;
      for (int p = 0; p < 12; p++) begin
         if (p % 4 == 0)
            set_grid(CfgW'($urandom_range(0, 511)), CfgW'($urandom_range(0, 511)),
                     CfgW'($urandom_range(0, 511)));
         else
            set_grid(CfgW'($urandom_range(1, 6)), CfgW'($urandom_range(1, 6)),
                     CfgW'($urandom_range(1, 6)));
         random_phase(110);
      end
   endtask

   task automatic test_backpressure;
      set_grid(9'd5, 9'd4, 9'd3);
      hold_off = 200;
      tx_idle_on = 1'b0;
      random_phase(150);
      tx_idle_on = 1'b1;
      drain();   // sender pauses until everything is back
      random_phase(50);
   endtask

   task automatic test_full_rate;
      set_grid(9'd7, 9'd3, 9'd9);
      rx_idle_on = 1'b0;
      tx_idle_on = 1'b0;
      random_phase(250);
   endtask

   initial begin
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      test_reset_grid();
      test_extremes();
      test_random_grids();
      test_backpressure();
      test_full_rate();
      drain();
      if (error_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
